FILE: hdl/afr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

    localparam int COORD_W    = 48;
    localparam int TRIG_W     = 32;
    localparam int COEF_W     = TRIG_W + 1;
    localparam int FRAC_W     = 30;
    localparam int LOW_W      = COORD_W / 2;
    localparam int HIGH_W     = COORD_W - LOW_W;
    localparam int SUM_W      = COORD_W + 35;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TRIG_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [TRIG_W-1:0]  trig_t;
    typedef logic signed [COEF_W-1:0]  coef_t;

    localparam trig_t TRIG_ONE = TRIG_W'(1) << FRAC_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENU_UVW = 2'd0,
        MODE_XYZ_ENU = 2'd1,
        MODE_ENU_XYZ = 2'd2,
        MODE_PASS    = 2'd3
    } afr_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_SIN_FIRST  = 3'd1,
        REG_COS_FIRST  = 3'd2,
        REG_SIN_SECOND = 3'd3,
        REG_COS_SECOND = 3'd4,
        REG_SIN_THIRD  = 3'd5,
        REG_COS_THIRD  = 3'd6
    } afr_reg_t;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } afr_axis_t;

    typedef struct packed {
        coord_t coord_a;
        coord_t coord_b;
        coord_t coord_c;
        logic   last_in;
    } afr_in_t;

    typedef struct packed {
        coord_t rot_a;
        coord_t rot_b;
        coord_t rot_c;
        logic   last_out;
    } afr_out_t;

    typedef struct packed {
        coord_t a;
        coord_t b;
        coord_t c;
        logic   last;
    } afr_vec_t;

    // One plane rotation: first' = cos*p + sin_neg*q, second' = sin*p + cos*q.
    typedef struct packed {
        afr_axis_t axis;
        coef_t     cos_k;
        coef_t     sin_k;
        coef_t     sin_neg;
    } afr_rot_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/antenna_frame_rotation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A position's result is offered at the output register once it has passed every
// register stage of the cells. Throughput: one position per cycle while out_ready
// holds, set by three rotation cells of three register stages each (partial
// products, wide sum, rounding and saturation).
// Reset clears the pipeline and sets mode 0 with zero sines and unit cosines.

module antenna_frame_rotation_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [afr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [afr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire afr_pkg::afr_in_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output afr_pkg::afr_out_t                  out_data
);
    import afr_pkg::*;

    localparam int CELLS = 3;

    afr_mode_t mode_reg, mode_next;
    trig_t     sin_first_reg, sin_first_next;
    trig_t     cos_first_reg, cos_first_next;
    trig_t     sin_second_reg, sin_second_next;
    trig_t     cos_second_reg, cos_second_next;
    trig_t     sin_third_reg, sin_third_next;
    trig_t     cos_third_reg, cos_third_next;

    coef_t sf, nsf, cf, ss, nss, cs, st, nst, ct;

    afr_rot_ctl_t cell_ctl   [CELLS];
    afr_vec_t     cell_vec   [CELLS+1];
    logic         cell_valid [CELLS+1];
    logic         cell_ready [CELLS+1];
    afr_vec_t     res;

    always_comb
    begin
        mode_next       = mode_reg;
        sin_first_next  = sin_first_reg;
        cos_first_next  = cos_first_reg;
        sin_second_next = sin_second_reg;
        cos_second_next = cos_second_reg;
        sin_third_next  = sin_third_reg;
        cos_third_next  = cos_third_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MODE:       mode_next       = afr_mode_t'(cfg_data[MODE_W-1:0]);
                REG_SIN_FIRST:  sin_first_next  = cfg_data;
                REG_COS_FIRST:  cos_first_next  = cfg_data;
                REG_SIN_SECOND: sin_second_next = cfg_data;
                REG_COS_SECOND: cos_second_next = cfg_data;
                REG_SIN_THIRD:  sin_third_next  = cfg_data;
                REG_COS_THIRD:  cos_third_next  = cfg_data;
                default:        mode_next       = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_ENU_UVW;
            sin_first_reg  <= '0;
            cos_first_reg  <= TRIG_ONE;
            sin_second_reg <= '0;
            cos_second_reg <= TRIG_ONE;
            sin_third_reg  <= '0;
            cos_third_reg  <= TRIG_ONE;
        end
        else
        begin
            mode_reg       <= mode_next;
            sin_first_reg  <= sin_first_next;
            cos_first_reg  <= cos_first_next;
            sin_second_reg <= sin_second_next;
            cos_second_reg <= cos_second_next;
            sin_third_reg  <= sin_third_next;
            cos_third_reg  <= cos_third_next;
        end
    end

    always_comb
    begin
        sf  = COEF_W'(sin_first_reg);
        nsf = -sf;
        cf  = COEF_W'(cos_first_reg);
        ss  = COEF_W'(sin_second_reg);
        nss = -ss;
        cs  = COEF_W'(cos_second_reg);
        st  = COEF_W'(sin_third_reg);
        nst = -st;
        ct  = COEF_W'(cos_third_reg);

        cell_ctl[0] = '{axis: AXIS_X, cos_k: cf, sin_k: nsf, sin_neg: sf};
        cell_ctl[1] = '{axis: AXIS_Y, cos_k: cs, sin_k: nss, sin_neg: ss};
        cell_ctl[2] = '{axis: AXIS_NONE, cos_k: ct, sin_k: st, sin_neg: nst};

        unique case (mode_reg)
            MODE_ENU_UVW:
            begin
                cell_ctl[1].sin_k   = ss;
                cell_ctl[1].sin_neg = nss;
                cell_ctl[2].axis    = AXIS_X;
            end
            MODE_XYZ_ENU:
            begin
                cell_ctl[0].axis = AXIS_Z;
            end
            MODE_ENU_XYZ:
            begin
                cell_ctl[0].axis = AXIS_X;
            end
            MODE_PASS:
            begin
                cell_ctl[0].axis = AXIS_NONE;
                cell_ctl[1].axis = AXIS_NONE;
            end
        endcase
    end

    assign cell_vec[0]   = '{a: in_data.coord_a, b: in_data.coord_b,
                             c: in_data.coord_c, last: in_data.last_in};
    assign cell_valid[0] = in_valid;
    assign in_ready      = cell_ready[0];

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        afr_rot_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[i]),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_vec    (cell_vec[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_vec   (cell_vec[i+1])
        );
    end

    assign res               = cell_vec[CELLS];
    assign out_valid         = cell_valid[CELLS];
    assign cell_ready[CELLS] = out_ready;

    always_comb
    begin
        out_data.last_out = res.last;
        unique case (mode_reg) inside
            MODE_XYZ_ENU:
            begin
                out_data.rot_a = res.b;
                out_data.rot_b = res.c;
                out_data.rot_c = res.a;
            end
            MODE_ENU_XYZ:
            begin
                out_data.rot_a = res.c;
                out_data.rot_b = res.a;
                out_data.rot_c = res.b;
            end
            MODE_ENU_UVW, MODE_PASS:
            begin
                out_data.rot_a = res.a;
                out_data.rot_b = res.b;
                out_data.rot_c = res.c;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/afr_rot_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_rot_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire afr_pkg::afr_rot_ctl_t ctl,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire afr_pkg::afr_vec_t     in_vec,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output afr_pkg::afr_vec_t          out_vec
);
    import afr_pkg::*;

    localparam int PL_W    = LOW_W + 1 + COEF_W;
    localparam int PH_W    = HIGH_W + COEF_W;
    localparam int SHIFT_W = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic s1_ready, s2_ready, s3_ready;

    coord_t                   p, q;
    logic signed [LOW_W:0]    p_lo, q_lo;
    logic signed [HIGH_W-1:0] p_hi, q_hi;

    logic signed [PH_W-1:0] p1h_reg, q1h_reg, p2h_reg, q2h_reg;
    logic signed [PL_W-1:0] p1l_reg, q1l_reg, p2l_reg, q2l_reg;
    afr_vec_t               s1_vec_reg, s2_vec_reg, s3_vec_reg, s3_vec_next;
    afr_axis_t              s1_axis_reg, s2_axis_reg;

    logic signed [SUM_W-1:0] sum1, sum2, sum1_reg, sum2_reg;
    coord_t                  rot1, rot2;

    function automatic coord_t round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SHIFT_W-1:0]  sh;
        logic [SHIFT_W-COORD_W:0]   top;
        coord_t                     r;
        sh  = SHIFT_W'(s >>> FRAC_W);
        top = sh[SHIFT_W-1:COORD_W-1];
        if ((&top) || !(|top)) begin
            r = sh[COORD_W-1:0];
        end
        else if (sh[SHIFT_W-1]) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s3_valid_reg;
    assign out_vec   = s3_vec_reg;

    always_comb
    begin
        s1_valid_next = s1_ready ? in_valid     : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_comb
    begin
        case (ctl.axis)
            AXIS_X:
            begin
                p = in_vec.b;
                q = in_vec.c;
            end
            AXIS_Y:
            begin
                p = in_vec.a;
                q = in_vec.c;
            end
            AXIS_Z:
            begin
                p = in_vec.a;
                q = in_vec.b;
            end
            AXIS_NONE:
            begin
                p = in_vec.a;
                q = in_vec.b;
            end
        endcase
        p_lo = {1'b0, p[LOW_W-1:0]};
        q_lo = {1'b0, q[LOW_W-1:0]};
        p_hi = p[COORD_W-1:LOW_W];
        q_hi = q[COORD_W-1:LOW_W];
    end

    always_comb
    begin
        sum1 = ((SUM_W'(p1h_reg) + SUM_W'(q1h_reg)) <<< LOW_W)
             + SUM_W'(p1l_reg) + SUM_W'(q1l_reg) + ROUND_HALF;
        sum2 = ((SUM_W'(p2h_reg) + SUM_W'(q2h_reg)) <<< LOW_W)
             + SUM_W'(p2l_reg) + SUM_W'(q2l_reg) + ROUND_HALF;
    end

    always_comb
    begin
        rot1        = round_sat(sum1_reg);
        rot2        = round_sat(sum2_reg);
        s3_vec_next = s2_vec_reg;
        case (s2_axis_reg)
            AXIS_X:
            begin
                s3_vec_next.b = rot1;
                s3_vec_next.c = rot2;
            end
            AXIS_Y:
            begin
                s3_vec_next.a = rot1;
                s3_vec_next.c = rot2;
            end
            AXIS_Z:
            begin
                s3_vec_next.a = rot1;
                s3_vec_next.b = rot2;
            end
            AXIS_NONE:
            begin
                s3_vec_next = s2_vec_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            p1h_reg     <= p_hi * $signed(ctl.cos_k);
            q1h_reg     <= q_hi * $signed(ctl.sin_neg);
            p1l_reg     <= p_lo * $signed(ctl.cos_k);
            q1l_reg     <= q_lo * $signed(ctl.sin_neg);
            p2h_reg     <= p_hi * $signed(ctl.sin_k);
            q2h_reg     <= q_hi * $signed(ctl.cos_k);
            p2l_reg     <= p_lo * $signed(ctl.sin_k);
            q2l_reg     <= q_lo * $signed(ctl.cos_k);
            s1_vec_reg  <= in_vec;
            s1_axis_reg <= ctl.axis;
        end
        if (s2_ready && s1_valid_reg)
        begin
            sum1_reg    <= sum1;
            sum2_reg    <= sum2;
            s2_vec_reg  <= s1_vec_reg;
            s2_axis_reg <= s1_axis_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_vec_reg <= s3_vec_next;
        end
    end

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("Cell refused a transfer while a stage was empty.");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("Accepted transfer did not reach the first stage.");

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_ready && s2_axis_reg == AXIS_NONE)
        |=> (out_vec == $past(s2_vec_reg)))
        else $error("Bypassed position was altered.");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !s2_valid_reg) |=> !out_valid)
        else $error("Result appeared without an item behind it.");

endmodule

`default_nettype wire

FILE: tb/tb_antenna_frame_rotation_top.sv
`timescale 1ns / 1ps

module tb_antenna_frame_rotation_top;

    import afr_pkg::*;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (FRAC_W - 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int ITEM_TARGET  = 1150;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_BACKLOG = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    afr_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    afr_out_t out_data;

    afr_in_t position_queue[$];
    afr_out_t rotated_queue[$];
    afr_out_t want;

    afr_mode_t mode_q = MODE_ENU_UVW;
    trig_t trig_q [0:7];

    int queued_total = 0;
    int accepted_count = 0;
    int err_count = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;
    logic in_taken = 1'b0;

    afr_reg_t sin_reg [3] = '{REG_SIN_FIRST, REG_SIN_SECOND, REG_SIN_THIRD};
    afr_reg_t cos_reg [3] = '{REG_COS_FIRST, REG_COS_SECOND, REG_COS_THIRD};

    antenna_frame_rotation_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint round_sum(longint p, longint wp, longint q, longint wq);
        logic signed [127:0] pw, wpw, qw, wqw, acc;
        pw = p;
        wpw = wp;
        qw = q;
        wqw = wq;
        acc = (pw * wpw + qw * wqw + ROUND_HALF) >>> FRAC_W;
        if (acc > COORD_MAX)
            return COORD_MAX;
        if (acc < COORD_MIN)
            return COORD_MIN;
        return acc[63:0];
    endfunction

    function automatic afr_out_t rotate_position(afr_in_t p);
        longint a, b, c, t, sf, cf, ss, cs, st, ct;
        afr_out_t r;
        a = $signed(p.coord_a);
        b = $signed(p.coord_b);
        c = $signed(p.coord_c);
        sf = trig_q[REG_SIN_FIRST];
        cf = trig_q[REG_COS_FIRST];
        ss = trig_q[REG_SIN_SECOND];
        cs = trig_q[REG_COS_SECOND];
        st = trig_q[REG_SIN_THIRD];
        ct = trig_q[REG_COS_THIRD];
        case (mode_q)
            MODE_ENU_UVW:
            begin
                t = round_sum(b, cf, c, sf);
                c = round_sum(b, -sf, c, cf);
                b = t;
                t = round_sum(a, cs, c, -ss);
                c = round_sum(a, ss, c, cs);
                a = t;
                t = round_sum(b, ct, c, -st);
                c = round_sum(b, st, c, ct);
                b = t;
            end
            MODE_XYZ_ENU:
            begin
                t = round_sum(a, cf, b, sf);
                b = round_sum(a, -sf, b, cf);
                a = t;
                t = round_sum(a, cs, c, ss);
                c = round_sum(a, -ss, c, cs);
                a = t;
                t = a;
                a = b;
                b = c;
                c = t;
            end
            MODE_ENU_XYZ:
            begin
                t = round_sum(b, cf, c, sf);
                c = round_sum(b, -sf, c, cf);
                b = t;
                t = round_sum(a, cs, c, ss);
                c = round_sum(a, -ss, c, cs);
                a = t;
                t = c;
                c = b;
                b = a;
                a = t;
            end
            default:
            begin
            end
        endcase
        r.rot_a = a[COORD_W-1:0];
        r.rot_b = b[COORD_W-1:0];
        r.rot_c = c[COORD_W-1:0];
        r.last_out = p.last_in;
        return r;
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint make_coord();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return longint'($urandom_range(0, 131071)) - 65536;
            3, 4, 5: return $signed(wide) >>> 24;
            default: return $signed(wide[COORD_W-1:0]);
        endcase
    endfunction

    function automatic trig_t pick_trig();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return {1'b1, {(TRIG_W-1){1'b0}}};
                    1: return {1'b0, {(TRIG_W-1){1'b1}}};
                    2: return TRIG_ONE;
                    3: return -TRIG_ONE;
                    default: return '0;
                endcase
            end
            default: return longint'($urandom_range(0, 32'h8000_0000)) - 64'h4000_0000;
        endcase
    endfunction

    task automatic queue_position(longint a, longint b, longint c, logic last);
        afr_in_t item;
        item.coord_a = a[COORD_W-1:0];
        item.coord_b = b[COORD_W-1:0];
        item.coord_c = c[COORD_W-1:0];
        item.last_in = last;
        position_queue.push_back(item);
        queued_total++;
    endtask

    // The block holds no items once this returns, so registers may change.
    task automatic wait_drained();
        while (accepted_count != queued_total || rotated_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_MODE: mode_q = afr_mode_t'(data[MODE_W-1:0]);
            REG_SIN_FIRST, REG_COS_FIRST, REG_SIN_SECOND,
            REG_COS_SECOND, REG_SIN_THIRD, REG_COS_THIRD: trig_q[idx] = data;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic report_field(string name, logic [COORD_W-1:0] exp_v,
                                logic [COORD_W-1:0] got_v);
        err_count++;
        $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (position_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= position_queue.pop_front();
                    gap_left <= pick_gap(send_steady);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_count >= HOLD_AT
                 && position_queue.size() >= HOLD_BACKLOG)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= pick_gap(recv_steady);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("antenna_frame_rotation_top: mismatch");
            $finish;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (rst_n && in_valid && in_ready)
            begin
                rotated_queue.push_back(rotate_position(in_data));
                accepted_count++;
            end
            if (rst_n && out_valid && out_ready)
            begin
                if (rotated_queue.size() == 0)
                begin
                    report_field("unexpected transfer, rot_a", '0, out_data.rot_a);
                end
                else
                begin
                    want = rotated_queue.pop_front();
                    if (out_data.rot_a !== want.rot_a)
                        report_field("rot_a", want.rot_a, out_data.rot_a);
                    if (out_data.rot_b !== want.rot_b)
                        report_field("rot_b", want.rot_b, out_data.rot_b);
                    if (out_data.rot_c !== want.rot_c)
                        report_field("rot_c", want.rot_c, out_data.rot_c);
                    if (out_data.last_out !== want.last_out)
                        report_field("last_out", want.last_out, out_data.last_out);
                end
            end
        end
    end

    initial
    begin
        int count;
        real ang;
        trig_t s_v, c_v;
        logic [CFG_DATA_W-1:0] mode_word;
        int r;

        trig_q = '{default: '0};
        trig_q[REG_COS_FIRST] = TRIG_ONE;
        trig_q[REG_COS_SECOND] = TRIG_ONE;
        trig_q[REG_COS_THIRD] = TRIG_ONE;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers as left by reset: every rotation is the identity.
        queue_position(0, 0, 0, 1'b0);
        queue_position(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_position(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_position(-1, 1, COORD_MIN, 1'b1);
        queue_position(COORD_MAX, COORD_MIN, 0, 1'b0);
        wait_drained();

        // Writes to the spare index must leave every register unchanged, and
        // trig values beyond unity are used as they stand.
        write_reg(REG_SPARE, 32'hDEAD_BEEF);
        write_reg(REG_MODE, MODE_ENU_UVW);
        write_reg(REG_SIN_FIRST, TRIG_ONE);
        write_reg(REG_COS_FIRST, '0);
        write_reg(REG_SIN_SECOND, {1'b1, {(TRIG_W-1){1'b0}}});
        write_reg(REG_COS_SECOND, {1'b0, {(TRIG_W-1){1'b1}}});
        write_reg(REG_SIN_THIRD, -TRIG_ONE);
        write_reg(REG_COS_THIRD, -TRIG_ONE);
        write_reg(REG_SPARE, 32'h1234_5678);
        queue_position(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_position(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        queue_position(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        queue_position(12345, -67890, 1, 1'b1);
        wait_drained();

        // Upper bits of the mode word are dropped.
        write_reg(REG_MODE, {30'h3FFF_FFFF, MODE_XYZ_ENU});
        write_reg(REG_SIN_FIRST, TRIG_ONE);
        write_reg(REG_COS_FIRST, TRIG_ONE);
        write_reg(REG_SIN_SECOND, TRIG_ONE);
        write_reg(REG_COS_SECOND, TRIG_ONE);
        queue_position(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        queue_position(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
        queue_position(COORD_MAX, COORD_MAX, 0, 1'b0);
        queue_position(-1, -1, -1, 1'b1);
        wait_drained();

        write_reg(REG_MODE, MODE_ENU_XYZ);
        write_reg(REG_SIN_FIRST, -TRIG_ONE);
        write_reg(REG_COS_FIRST, -TRIG_ONE);
        write_reg(REG_SIN_SECOND, -TRIG_ONE);
        write_reg(REG_COS_SECOND, {1'b1, {(TRIG_W-1){1'b0}}});
        queue_position(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_position(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_position(0, COORD_MAX, COORD_MIN, 1'b1);
        queue_position(1, 2, 3, 1'b0);
        wait_drained();

        write_reg(REG_MODE, MODE_PASS);
        queue_position(COORD_MAX, COORD_MIN, -1, 1'b1);
        queue_position(COORD_MIN, COORD_MAX, 0, 1'b0);
        queue_position(make_coord(), make_coord(), make_coord(), 1'b1);
        wait_drained();

        while (queued_total < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            mode_word = (r < 3) ? MODE_ENU_UVW : (r < 6) ? MODE_XYZ_ENU
                      : (r < 9) ? MODE_ENU_XYZ : MODE_PASS;
            if ($urandom_range(0, 3) == 0)
                mode_word[CFG_DATA_W-1:MODE_W] = $urandom;
            write_reg(REG_MODE, mode_word);
            for (int k = 0; k < 3; k++)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    ang = $urandom_range(0, 359999) * 3.14159265358979 / 180000.0;
                    s_v = $rtoi($sin(ang) * 1073741824.0);
                    c_v = $rtoi($cos(ang) * 1073741824.0);
                end
                else
                begin
                    s_v = pick_trig();
                    c_v = pick_trig();
                end
                write_reg(sin_reg[k], s_v);
                write_reg(cos_reg[k], c_v);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, $urandom);
            send_steady <= ($urandom_range(0, 4) == 0);
            recv_steady <= ($urandom_range(0, 4) == 0);
            count = $urandom_range(40, 120);
            for (int n = 0; n < count; n++)
                queue_position(make_coord(), make_coord(), make_coord(), $urandom_range(0, 1));
            wait_drained();
        end

        if (err_count == 0 && rotated_queue.size() == 0)
            $display("antenna_frame_rotation_top: match");
        else
            $display("antenna_frame_rotation_top: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
hdl/afr_pkg.sv
hdl/afr_rot_cell.sv
hdl/antenna_frame_rotation_top.sv
tb/tb_antenna_frame_rotation_top.sv
